>>> hdl/tbdlp_pkg.sv
// Shared types and constants for the three-button debounce / long-press unit.
// No dependencies; used by every module under hdl.
package tbdlp_pkg;

    localparam int unsigned NUM_BTN    = 3;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd200;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_SELECT = 3'd3,
        EV_BACK   = 3'd4
    } event_code_t;

    // What a lane found for the current word
    typedef struct packed {
        logic fire;   // stable level changes now
        logic level;  // raw level of this word
    } lane_status_t;

    // What the merge stage lets a lane keep
    typedef struct packed {
        logic settle; // keep change stamp and stable level
        logic raw;    // keep raw level as previous level
    } lane_commit_t;

endpackage

>>> hdl/tbdlp_lane.sv
// One debounce lane: previous raw level, stable level and change stamp of a button.
// Depends on tbdlp_pkg.
module tbdlp_lane
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [tbdlp_pkg::TIME_W-1:0]     now_ms,
    input  logic                             level,
    input  logic [tbdlp_pkg::CFG_W-1:0]      debounce_ms,
    input  tbdlp_pkg::lane_commit_t          commit,
    output tbdlp_pkg::lane_status_t          status
);

    logic                         raw_prev_reg;
    logic                         stable_reg;
    logic [tbdlp_pkg::TIME_W-1:0] stamp_reg;

    logic [tbdlp_pkg::TIME_W-1:0] stamp_next;
    logic [tbdlp_pkg::TIME_W-1:0] elapsed;

    always_comb
    begin
        // Restamp on a raw change, then compare wrapped elapsed time
        stamp_next   = (level != raw_prev_reg) ? now_ms : stamp_reg;
        elapsed      = now_ms - stamp_next;
        status.level = level;
        status.fire  = (elapsed > {{(tbdlp_pkg::TIME_W-tbdlp_pkg::CFG_W){1'b0}}, debounce_ms})
                       && (level != stable_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg <= 1'b1;
            stable_reg   <= 1'b1;
            stamp_reg    <= '0;
        end
        else if (accept)
        begin
            if (commit.settle)
            begin
                stamp_reg <= stamp_next;
                if (status.fire)
                begin
                    stable_reg <= level;
                end
            end
            if (commit.raw)
            begin
                raw_prev_reg <= level;
            end
        end
    end

endmodule

>>> hdl/tbdlp_merge.sv
// Merge stage: first-event-wins priority over the lanes plus the select
// button's hold, long-press and repeat state. Depends on tbdlp_pkg.
module tbdlp_merge
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [tbdlp_pkg::TIME_W-1:0]         now_ms,
    input  logic [tbdlp_pkg::CFG_W-1:0]          long_press_ms,
    input  logic [tbdlp_pkg::CFG_W-1:0]          repeat_ms,
    input  tbdlp_pkg::lane_status_t              status_down,
    input  tbdlp_pkg::lane_status_t              status_up,
    input  tbdlp_pkg::lane_status_t              status_sel,
    output tbdlp_pkg::lane_commit_t              commit_down,
    output tbdlp_pkg::lane_commit_t              commit_up,
    output tbdlp_pkg::lane_commit_t              commit_sel,
    output tbdlp_pkg::event_code_t               event_code
);

    localparam int unsigned PAD_W = tbdlp_pkg::TIME_W - tbdlp_pkg::CFG_W;

    logic [tbdlp_pkg::TIME_W-1:0] press_start_reg;
    logic [tbdlp_pkg::TIME_W-1:0] last_repeat_reg;
    logic                         held_reg;
    logic                         long_done_reg;

    logic                         ev_down;
    logic                         ev_up;
    logic                         reach_up;
    logic                         reach_sel;
    logic                         press;
    logic                         release_ev;
    logic                         ev_sel;
    logic                         held_next;
    logic                         long_done_next;
    logic [tbdlp_pkg::TIME_W-1:0] press_start_next;
    logic                         hold_ok;
    logic                         back_first;
    logic                         back_rep;

    always_comb
    begin
        ev_down   = status_down.fire && status_down.level;
        reach_up  = !ev_down;
        ev_up     = status_up.fire && status_up.level;
        reach_sel = reach_up && !ev_up;

        press      = status_sel.fire && !status_sel.level;
        release_ev = status_sel.fire && status_sel.level;
        ev_sel     = release_ev && !long_done_reg;

        // Hold state as the select lane leaves it
        held_next        = press ? 1'b1 : (release_ev ? 1'b0 : held_reg);
        press_start_next = press ? now_ms : press_start_reg;
        long_done_next   = press ? 1'b0 : long_done_reg;

        hold_ok    = reach_sel && !ev_sel && held_next
                     && ((now_ms - press_start_next) > {{PAD_W{1'b0}}, long_press_ms});
        back_first = hold_ok && !long_done_next;
        back_rep   = hold_ok && long_done_next
                     && ((now_ms - last_repeat_reg) > {{PAD_W{1'b0}}, repeat_ms});

        commit_down.settle = 1'b1;
        commit_down.raw    = !ev_down;
        commit_up.settle   = reach_up;
        commit_up.raw      = reach_up && !ev_up;
        commit_sel.settle  = reach_sel;
        commit_sel.raw     = reach_sel && !ev_sel;

        if (ev_down)
        begin
            event_code = tbdlp_pkg::EV_DOWN;
        end
        else if (ev_up)
        begin
            event_code = tbdlp_pkg::EV_UP;
        end
        else if (reach_sel && ev_sel)
        begin
            event_code = tbdlp_pkg::EV_SELECT;
        end
        else if (back_first || back_rep)
        begin
            event_code = tbdlp_pkg::EV_BACK;
        end
        else
        begin
            event_code = tbdlp_pkg::EV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_start_reg <= '0;
            last_repeat_reg <= '0;
            held_reg        <= 1'b0;
            long_done_reg   <= 1'b0;
        end
        else if (accept && reach_sel)
        begin
            held_reg        <= held_next;
            press_start_reg <= press_start_next;
            long_done_reg   <= long_done_next || back_first;
            if (back_first || back_rep)
            begin
                last_repeat_reg <= now_ms;
            end
        end
    end

endmodule

>>> hdl/three_button_debounce_long_press_unit.sv
// Three-button debouncer with long press and auto repeat. Each input word is one
// sample: a 32-bit millisecond time and three active-low raw button levels.
// Exactly one output word follows each input word, in the cycle after it is taken,
// carrying an event code (none, down, up, select, back). The block takes one
// word every cycle while the output slot is empty or m_tready is high; the three
// debounce lanes and merge logic feed a single output register stage, which lets
// a new word in only while the previous result is being drained or none waits.
// Configuration writes (debounce, long-press, repeat delays) are taken at once
// and should only be issued while no result is pending.
// Depends on tbdlp_pkg, tbdlp_lane and tbdlp_merge.
module three_button_debounce_long_press_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Sample stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [31:0] now_ms, [32] pin_down_btn, [33] pin_up_btn, [34] pin_select_btn,
    // [39:35] zero
    input  logic [tbdlp_pkg::IN_DATA_W-1:0]       s_tdata,

    // Event stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [2:0] event_code, [7:3] zero
    output logic [tbdlp_pkg::OUT_DATA_W-1:0]      m_tdata,

    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tbdlp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tbdlp_pkg::CFG_W-1:0]           cfg_data
);

    logic [tbdlp_pkg::CFG_W-1:0] debounce_reg;
    logic [tbdlp_pkg::CFG_W-1:0] long_press_reg;
    logic [tbdlp_pkg::CFG_W-1:0] repeat_reg;

    logic                        out_valid_reg;
    tbdlp_pkg::event_code_t      out_code_reg;

    logic                        accept;
    logic [tbdlp_pkg::TIME_W-1:0] now_ms;
    logic                        pin_down_btn;
    logic                        pin_up_btn;
    logic                        pin_select_btn;

    tbdlp_pkg::lane_status_t     status_down;
    tbdlp_pkg::lane_status_t     status_up;
    tbdlp_pkg::lane_status_t     status_sel;
    tbdlp_pkg::lane_commit_t     commit_down;
    tbdlp_pkg::lane_commit_t     commit_up;
    tbdlp_pkg::lane_commit_t     commit_sel;
    tbdlp_pkg::event_code_t      event_code;

    // Unpack the sample word
    assign now_ms         = s_tdata[tbdlp_pkg::TIME_W-1:0];
    assign pin_down_btn   = s_tdata[tbdlp_pkg::TIME_W];
    assign pin_up_btn     = s_tdata[tbdlp_pkg::TIME_W+1];
    assign pin_select_btn = s_tdata[tbdlp_pkg::TIME_W+2];

    // Take a new word whenever the output slot is empty or being drained
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(tbdlp_pkg::OUT_DATA_W-3){1'b0}}, out_code_reg};
    assign cfg_ready = 1'b1;

    // Configuration registers; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= tbdlp_pkg::DEBOUNCE_RST;
            long_press_reg <= tbdlp_pkg::LONG_PRESS_RST;
            repeat_reg     <= tbdlp_pkg::REPEAT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tbdlp_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                tbdlp_pkg::REG_LONG_PRESS: long_press_reg <= cfg_data;
                tbdlp_pkg::REG_REPEAT:     repeat_reg     <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Three debounce lanes work on the sample side by side
    tbdlp_lane u_lane_down
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .now_ms      (now_ms),
        .level       (pin_down_btn),
        .debounce_ms (debounce_reg),
        .commit      (commit_down),
        .status      (status_down)
    );

    tbdlp_lane u_lane_up
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .now_ms      (now_ms),
        .level       (pin_up_btn),
        .debounce_ms (debounce_reg),
        .commit      (commit_up),
        .status      (status_up)
    );

    tbdlp_lane u_lane_sel
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .now_ms      (now_ms),
        .level       (pin_select_btn),
        .debounce_ms (debounce_reg),
        .commit      (commit_sel),
        .status      (status_sel)
    );

    // Merge: the first button with an event wins and later lanes drop their updates
    tbdlp_merge u_merge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .now_ms        (now_ms),
        .long_press_ms (long_press_reg),
        .repeat_ms     (repeat_reg),
        .status_down   (status_down),
        .status_up     (status_up),
        .status_sel    (status_sel),
        .commit_down   (commit_down),
        .commit_up     (commit_up),
        .commit_sel    (commit_sel),
        .event_code    (event_code)
    );

    // Output register: hold the event until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_code_reg  <= tbdlp_pkg::EV_NONE;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
            out_code_reg  <= event_code;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

>>> tb/tb.sv
// Self-checking testbench for three_button_debounce_long_press_unit.
// Drives time-stamped button samples, predicts every event code in-bench and
// compares the results word by word. Depends on tbdlp_pkg and the unit RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Index that maps to no register: the unit must ignore the write
    localparam logic [tbdlp_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int unsigned HOLD_OFF_CYCLES = 40;
    localparam int unsigned MAX_REPORTS     = 10;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  s_tvalid;
    logic                                  s_tready;
    logic [tbdlp_pkg::IN_DATA_W-1:0]       s_tdata;
    logic                                  m_tvalid;
    logic                                  m_tready;
    logic [tbdlp_pkg::OUT_DATA_W-1:0]      m_tdata;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [tbdlp_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [tbdlp_pkg::CFG_W-1:0]           cfg_data;

    three_button_debounce_long_press_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [31:0] now_ms, [32] down, [33] up, [34] select
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [2:0] event_code
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Debounce / long-press predictor state (bench copy)
    // ------------------------------------------------------------------
    logic [tbdlp_pkg::CFG_W-1:0]  dbnc_ms;
    logic [tbdlp_pkg::CFG_W-1:0]  long_ms;
    logic [tbdlp_pkg::CFG_W-1:0]  rpt_ms;
    logic [2:0]                   raw_last;        // bit 0 down, 1 up, 2 select
    logic [2:0]                   level_stable;
    logic [tbdlp_pkg::TIME_W-1:0] raw_stamp [tbdlp_pkg::NUM_BTN];
    logic [tbdlp_pkg::TIME_W-1:0] hold_start;
    logic [tbdlp_pkg::TIME_W-1:0] back_time;
    logic                         is_held;
    logic                         back_given;

    // Expected event codes, oldest first
    tbdlp_pkg::event_code_t events_due[$];

    // Bench bookkeeping
    int unsigned mismatch_count = 0;
    int unsigned samples_sent;
    int unsigned settings_used;
    int unsigned codes_seen [5] = '{default: 0};
    bit          idle_en;
    bit          hold_off_req;

    // Stimulus generator state: a virtual clock and a per-button press pattern
    logic [tbdlp_pkg::TIME_W-1:0] t_cursor;
    logic [2:0]                   btn_target;
    int unsigned                  btn_left [tbdlp_pkg::NUM_BTN];
    int unsigned                  btn_bounce [tbdlp_pkg::NUM_BTN];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_model();
        dbnc_ms      = tbdlp_pkg::DEBOUNCE_RST;
        long_ms      = tbdlp_pkg::LONG_PRESS_RST;
        rpt_ms       = tbdlp_pkg::REPEAT_RST;
        raw_last     = 3'b111;
        level_stable = 3'b111;
        for (int b = 0; b < tbdlp_pkg::NUM_BTN; b++)
            raw_stamp[b] = '0;
        hold_start = '0;
        back_time  = '0;
        is_held    = 1'b0;
        back_given = 1'b0;
    endfunction

    // Debounce one lane; true when its stable level flips on this sample.
    // Elapsed time wraps mod 2^32 since both operands are 32 bits.
    function automatic bit lane_flips(int b, logic lvl, logic [tbdlp_pkg::TIME_W-1:0] now);
        if (lvl != raw_last[b])
            raw_stamp[b] = now;
        if ((now - raw_stamp[b]) > {16'd0, dbnc_ms} && lvl != level_stable[b])
        begin
            level_stable[b] = lvl;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Lanes are visited down, up, select, then the hold check. The first
    // event ends the sample: that lane keeps its stamp but not its raw level.
    function automatic tbdlp_pkg::event_code_t predict_event(
        logic [tbdlp_pkg::TIME_W-1:0] now, logic [2:0] pins);
        for (int b = 0; b < 2; b++)
        begin
            if (lane_flips(b, pins[b], now) && level_stable[b])
                return (b == 0) ? tbdlp_pkg::EV_DOWN : tbdlp_pkg::EV_UP;
            raw_last[b] = pins[b];
        end
        if (lane_flips(2, pins[2], now))
        begin
            if (!level_stable[2])
            begin
                hold_start = now;
                is_held    = 1'b1;
                back_given = 1'b0;
            end
            else
            begin
                is_held = 1'b0;
                if (!back_given)
                    return tbdlp_pkg::EV_SELECT;
            end
        end
        raw_last[2] = pins[2];
        if (is_held && (now - hold_start) > {16'd0, long_ms})
        begin
            if (!back_given)
            begin
                back_given = 1'b1;
                back_time  = now;
                return tbdlp_pkg::EV_BACK;
            end
            if ((now - back_time) > {16'd0, rpt_ms})
            begin
                back_time = now;
                return tbdlp_pkg::EV_BACK;
            end
        end
        return tbdlp_pkg::EV_NONE;
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Time limit set well beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("timeout: %0d results still expected", events_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: ready pattern, with random stalls and one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        bit hold_off_done;
        hold_off_done = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                // Hold off long enough for the unit to fill and stall its input
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_done = 1'b1;
                m_tready <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    initial
    begin
        tbdlp_pkg::event_code_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (events_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result word: event_code=%0d", m_tdata[2:0]);
                end
                else
                begin
                    want = events_due.pop_front();
                    if (m_tdata[2:0] !== want || m_tdata[tbdlp_pkg::OUT_DATA_W-1:3] !== '0)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("event_code mismatch: expected %0d (%s), got %0d, pad=%h",
                                     want, want.name(), m_tdata[2:0],
                                     m_tdata[tbdlp_pkg::OUT_DATA_W-1:3]);
                    end
                    if (m_tdata[2:0] <= 3'd4)
                        codes_seen[m_tdata[2:0]]++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------
    // Offer one sample word; predict its event on the accepting edge
    task automatic send_sample(input logic [tbdlp_pkg::TIME_W-1:0] now,
                               input logic [2:0] pins);
        @(negedge clk);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, pins[2], pins[1], pins[0], now};
        do
            @(posedge clk);
        while (!s_tready);
        events_due.push_back(predict_event(now, pins));
        samples_sent++;
    endtask

    // Stop offering and hold until every expected word has come back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
    endtask

    // One register write; only called once the unit is drained
    task automatic write_reg(input logic [tbdlp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tbdlp_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tbdlp_pkg::REG_DEBOUNCE:   dbnc_ms = val;
            tbdlp_pkg::REG_LONG_PRESS: long_ms = val;
            tbdlp_pkg::REG_REPEAT:     rpt_ms  = val;
            default:                   ;   // no such register: ignored
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_delays(input logic [tbdlp_pkg::CFG_W-1:0] dbnc,
                              input logic [tbdlp_pkg::CFG_W-1:0] lng,
                              input logic [tbdlp_pkg::CFG_W-1:0] rpt);
        drain();
        write_reg(tbdlp_pkg::REG_DEBOUNCE, dbnc);
        write_reg(tbdlp_pkg::REG_LONG_PRESS, lng);
        write_reg(tbdlp_pkg::REG_REPEAT, rpt);
        settings_used++;
    endtask

    // Realistic button activity: each button alternates press and release,
    // held for a random number of samples, with contact bounce at each edge.
    // A small share of samples is noise: time jumps, repeated stamps, random pins.
    task automatic run_random(input int unsigned count, input int unsigned step_max,
                              input int unsigned hold_max);
        logic [2:0] pins;
        repeat (count)
        begin
            for (int b = 0; b < tbdlp_pkg::NUM_BTN; b++)
            begin
                if (btn_left[b] == 0)
                begin
                    btn_target[b] = ~btn_target[b];
                    btn_left[b]   = $urandom_range(1, hold_max);
                    // keep down/up released longer so select holds can run out
                    if (b < 2 && btn_target[b])
                        btn_left[b] = btn_left[b] * 2;
                    btn_bounce[b] = $urandom_range(0, 3);
                end
                btn_left[b]--;
                if (btn_bounce[b] != 0)
                begin
                    pins[b] = 1'($urandom_range(0, 1));
                    btn_bounce[b]--;
                end
                else
                begin
                    pins[b] = btn_target[b];
                end
            end
            case ($urandom_range(0, 49))
                0:       t_cursor = $urandom;
                1:       ;   // same time stamp again
                2:       pins = 3'($urandom_range(0, 7));
                default: t_cursor = t_cursor + $urandom_range(1, step_max);
            endcase
            send_sample(t_cursor, pins);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Hand-built presses at reset delays (50 / 1000 / 200): each event code,
    // first event wins, bounce restamp, long press with repeat, release after
    // a long press, and a press that spans the 32-bit time wrap.
    task automatic test_reset_delays();
        send_sample(32'd0,          3'b111);
        send_sample(32'hFFFF_FFFF,  3'b111);
        send_sample(32'd10,         3'b110);   // down pressed
        send_sample(32'd61,         3'b110);   // down stable, no event
        send_sample(32'd70,         3'b111);
        send_sample(32'd121,        3'b111);   // down released -> down
        send_sample(32'd130,        3'b101);   // up pressed
        send_sample(32'd181,        3'b101);
        send_sample(32'd190,        3'b111);
        send_sample(32'd241,        3'b011);   // up event hides select edge
        send_sample(32'd250,        3'b011);   // select edge seen now
        send_sample(32'd301,        3'b011);
        send_sample(32'd320,        3'b111);
        send_sample(32'd371,        3'b111);   // short release -> select
        send_sample(32'd400,        3'b011);
        send_sample(32'd420,        3'b111);   // bounce
        send_sample(32'd430,        3'b011);
        send_sample(32'd481,        3'b011);   // select stable down
        send_sample(32'd1482,       3'b011);   // long press -> back
        send_sample(32'd1683,       3'b011);   // repeat -> back
        send_sample(32'd1700,       3'b010);   // down glitch while held
        send_sample(32'd1884,       3'b011);   // repeat again
        send_sample(32'd1900,       3'b111);
        send_sample(32'd1951,       3'b111);   // release after back: none
        send_sample(32'hFFFF_FFC0,  3'b011);
        send_sample(32'h0000_0010,  3'b011);   // stable across the wrap
        send_sample(32'h0000_0020,  3'b111);
        send_sample(32'h0000_0060,  3'b111);   // select
        settings_used++;
    endtask

    task automatic test_default_activity();
        t_cursor = 32'd5000;
        run_random(350, 40, 80);
    endtask

    // Short delays, starting just below the time wrap
    task automatic test_short_delays_wrap();
        set_delays(16'd3, 16'd40, 16'd6);
        write_reg(REG_NONE, 16'hFFFF);   // must leave every delay alone
        t_cursor = 32'hFFFF_FF00;
        run_random(300, 4, 40);
    endtask

    task automatic test_zero_delays();
        set_delays(16'd0, 16'd0, 16'd0);
        run_random(150, 2, 8);
    endtask

    task automatic test_max_delays();
        set_delays(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(150, 20000, 30);
    endtask

    task automatic test_random_delays();
        logic [tbdlp_pkg::CFG_W-1:0] d, l, r;
        repeat (3)
        begin
            d = 16'($urandom_range(0, 100));
            l = 16'($urandom_range(0, 600));
            r = 16'($urandom_range(0, 150));
            set_delays(d, l, r);
            run_random(100, (d + r) / 4 + 2, 40);
        end
    endtask

    // Result side holds off while samples keep coming
    task automatic test_output_stall();
        hold_off_req = 1'b1;
        run_random(40, 8, 20);
    endtask

    // Full rate on both sides to finish
    task automatic test_full_rate();
        set_delays(16'd20, 16'd150, 16'd30);
        idle_en = 1'b0;
        run_random(150, 10, 40);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned missing;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = tbdlp_pkg::REG_DEBOUNCE;
        cfg_data  = '0;
        samples_sent   = 0;
        settings_used  = 0;
        idle_en      = 1'b1;
        hold_off_req = 1'b0;
        btn_target   = 3'b111;
        for (int b = 0; b < tbdlp_pkg::NUM_BTN; b++)
        begin
            btn_left[b]   = 0;
            btn_bounce[b] = 0;
        end
        clear_model();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_delays();
        test_default_activity();
        test_output_stall();
        test_short_delays_wrap();
        test_zero_delays();
        test_max_delays();
        test_random_delays();
        test_full_rate();

        drain();
        repeat (10) @(posedge clk);
        missing = events_due.size();
        if (missing != 0)
            $display("%0d expected results never arrived", missing);

        $display("Sent %0d button samples over %0d delay settings (zero, reset, full scale, random).",
                 samples_sent, settings_used);
        $display("Results seen: none %0d, down %0d, up %0d, select %0d, back %0d; mismatches %0d.",
                 codes_seen[0], codes_seen[1], codes_seen[2], codes_seen[3], codes_seen[4],
                 mismatch_count);
        if (mismatch_count == 0 && missing == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
hdl/tbdlp_pkg.sv
hdl/tbdlp_lane.sv
hdl/tbdlp_merge.sv
hdl/three_button_debounce_long_press_unit.sv
tb/tb.sv
